// ===== hw/rtl/cpuaf_pkg.sv =====
`timescale 1ns / 1ps

package cpuaf_pkg;

    typedef enum logic [4:0] {
        CMD_ADD     = 5'd0,
        CMD_ADC     = 5'd1,
        CMD_SUB     = 5'd2,
        CMD_SBC     = 5'd3,
        CMD_AND     = 5'd4,
        CMD_XOR     = 5'd5,
        CMD_OR      = 5'd6,
        CMD_CP      = 5'd7,
        CMD_INC     = 5'd8,
        CMD_DEC     = 5'd9,
        CMD_RLC     = 5'd10,
        CMD_RRC     = 5'd11,
        CMD_RL      = 5'd12,
        CMD_RR      = 5'd13,
        CMD_SLA     = 5'd14,
        CMD_SRA     = 5'd15,
        CMD_SWAP    = 5'd16,
        CMD_SRL     = 5'd17,
        CMD_BIT     = 5'd18,
        CMD_RES     = 5'd19,
        CMD_SET     = 5'd20,
        CMD_RLCA    = 5'd21,
        CMD_RRCA    = 5'd22,
        CMD_RLA     = 5'd23,
        CMD_RRA     = 5'd24,
        CMD_DAA     = 5'd25,
        CMD_CPL     = 5'd26,
        CMD_CCF     = 5'd27,
        CMD_SCF     = 5'd28,
        CMD_ADD16   = 5'd29,
        CMD_ADD_SP  = 5'd30
    } cmd_t;

    // Flag positions in the packed Z N H C nibble.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu_in_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } alu_out_t;

endpackage

// ===== hw/rtl/cpu_alu_with_flags_core.sv =====
`timescale 1ns / 1ps

// 8-bit CPU arithmetic unit with Z, N, H and C flags, plus the 16-bit pair add and the
// stack-pointer offset add. An item is taken whenever start is high; busy never rises,
// so one item can be issued in every cycle. Its result and flags appear on result and
// flags_out, marked by done for exactly one cycle, once the item has passed through the
// input register and then through the arithmetic logic into the result register. The
// receiver cannot stall the block and must take each result as it appears. No state is
// kept between items.

module cpu_alu_with_flags_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  cmd,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [2:0]  bit_index,
    input  logic [3:0]  flags_in,
    output logic        done,
    output logic [15:0] result,
    output logic [3:0]  flags_out
);

    cpuaf_pkg::alu_in_t  item_reg;
    cpuaf_pkg::alu_out_t alu_res;
    logic                valid_reg;
    logic                done_reg;
    logic [15:0]         result_reg;
    logic [3:0]          flags_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg.cmd       <= cmd;
            item_reg.operand_a <= operand_a;
            item_reg.operand_b <= operand_b;
            item_reg.bit_index <= bit_index;
            item_reg.flags_in  <= flags_in;
        end
        if (valid_reg)
        begin
            result_reg <= alu_res.result;
            flags_reg  <= alu_res.flags_out;
        end
    end

    cpuaf_alu u_alu
    (
        .item (item_reg),
        .res  (alu_res)
    );

    assign done      = done_reg;
    assign result    = result_reg;
    assign flags_out = flags_reg;

endmodule

// ===== hw/rtl/cpuaf_alu.sv =====
`timescale 1ns / 1ps

module cpuaf_alu
(
    input  cpuaf_pkg::alu_in_t  item,
    output cpuaf_pkg::alu_out_t res
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        ci;
    logic        t;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  diff9;
    logic [4:0]  hdiff5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic        daa60;
    logic        daa06;
    logic [7:0]  daa8;
    logic [16:0] sum17;
    logic [12:0] hsum13;
    logic [15:0] sp16;
    logic [4:0]  sph5;
    logic [8:0]  spc9;
    logic [7:0]  r8;
    logic [15:0] r;
    logic [3:0]  f;

    assign a  = item.operand_a[7:0];
    assign b  = item.operand_b[7:0];
    assign ci = item.flags_in[cpuaf_pkg::FLAG_C];
    assign t  = ((item.cmd == cpuaf_pkg::CMD_ADC) || (item.cmd == cpuaf_pkg::CMD_SBC)) ? ci : 1'b0;

    assign sum9   = {1'b0, a} + {1'b0, b} + {8'b0, t};
    assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t};
    assign diff9  = {1'b0, a} - {1'b0, b} - {8'b0, t};
    assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t};
    assign inc8   = a + 8'd1;
    assign dec8   = a - 8'd1;

    // Decimal adjust: corrections depend on whether the last operation subtracted.
    always_comb
    begin
        if (!item.flags_in[cpuaf_pkg::FLAG_N])
        begin
            daa60 = ci || (a > 8'h99);
            daa06 = item.flags_in[cpuaf_pkg::FLAG_H] || (a[3:0] > 4'd9);
            daa8  = a + (daa60 ? 8'h60 : 8'h00) + (daa06 ? 8'h06 : 8'h00);
        end
        else
        begin
            daa60 = ci;
            daa06 = item.flags_in[cpuaf_pkg::FLAG_H];
            daa8  = a - (daa60 ? 8'h60 : 8'h00) - (daa06 ? 8'h06 : 8'h00);
        end
    end

    assign sum17  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
    assign hsum13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
    assign sp16   = item.operand_a + {{8{b[7]}}, b};
    assign sph5   = {1'b0, item.operand_a[3:0]} + {1'b0, b[3:0]};
    assign spc9   = {1'b0, item.operand_a[7:0]} + {1'b0, b};

    always_comb
    begin
        r8 = 8'h00;
        r  = item.operand_a;
        f  = item.flags_in;
        unique case (item.cmd)
            cpuaf_pkg::CMD_ADD, cpuaf_pkg::CMD_ADC:
            begin
                r8 = sum9[7:0];
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 1'b0, hsum5[4], sum9[8]};
            end
            cpuaf_pkg::CMD_SUB, cpuaf_pkg::CMD_SBC:
            begin
                r8 = diff9[7:0];
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 1'b1, hdiff5[4], diff9[8]};
            end
            cpuaf_pkg::CMD_CP:
            begin
                f = {diff9[7:0] == 8'h00, 1'b1, hdiff5[4], diff9[8]};
            end
            cpuaf_pkg::CMD_AND:
            begin
                r8 = a & b;
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            cpuaf_pkg::CMD_XOR:
            begin
                r8 = a ^ b;
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 3'b000};
            end
            cpuaf_pkg::CMD_OR:
            begin
                r8 = a | b;
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 3'b000};
            end
            cpuaf_pkg::CMD_INC:
            begin
                r = {8'h00, inc8};
                f = {inc8 == 8'h00, 1'b0, inc8[3:0] == 4'h0, ci};
            end
            cpuaf_pkg::CMD_DEC:
            begin
                r = {8'h00, dec8};
                f = {dec8 == 8'h00, 1'b1, dec8[3:0] == 4'hF, ci};
            end
            cpuaf_pkg::CMD_RLC:
            begin
                r8 = {a[6:0], a[7]};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 2'b00, a[7]};
            end
            cpuaf_pkg::CMD_RRC:
            begin
                r8 = {a[0], a[7:1]};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            cpuaf_pkg::CMD_RL:
            begin
                r8 = {a[6:0], ci};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 2'b00, a[7]};
            end
            cpuaf_pkg::CMD_RR:
            begin
                r8 = {ci, a[7:1]};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            cpuaf_pkg::CMD_SLA:
            begin
                r8 = {a[6:0], 1'b0};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 2'b00, a[7]};
            end
            cpuaf_pkg::CMD_SRA:
            begin
                r8 = {a[7], a[7:1]};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            cpuaf_pkg::CMD_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 3'b000};
            end
            cpuaf_pkg::CMD_SRL:
            begin
                r8 = {1'b0, a[7:1]};
                r  = {8'h00, r8};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            cpuaf_pkg::CMD_BIT:
            begin
                f = {~a[item.bit_index], 1'b0, 1'b1, ci};
            end
            cpuaf_pkg::CMD_RES:
            begin
                r = {8'h00, a & ~(8'h01 << item.bit_index)};
            end
            cpuaf_pkg::CMD_SET:
            begin
                r = {8'h00, a | (8'h01 << item.bit_index)};
            end
            // The accumulator rotates always clear Z.
            cpuaf_pkg::CMD_RLCA:
            begin
                r = {8'h00, a[6:0], a[7]};
                f = {3'b000, a[7]};
            end
            cpuaf_pkg::CMD_RRCA:
            begin
                r = {8'h00, a[0], a[7:1]};
                f = {3'b000, a[0]};
            end
            cpuaf_pkg::CMD_RLA:
            begin
                r = {8'h00, a[6:0], ci};
                f = {3'b000, a[7]};
            end
            cpuaf_pkg::CMD_RRA:
            begin
                r = {8'h00, ci, a[7:1]};
                f = {3'b000, a[0]};
            end
            cpuaf_pkg::CMD_DAA:
            begin
                r = {8'h00, daa8};
                f = {daa8 == 8'h00, item.flags_in[cpuaf_pkg::FLAG_N], 1'b0, daa60};
            end
            cpuaf_pkg::CMD_CPL:
            begin
                r = {8'h00, ~a};
                f = item.flags_in | 4'b0110;
            end
            cpuaf_pkg::CMD_CCF:
            begin
                r = {8'h00, a};
                f = {item.flags_in[cpuaf_pkg::FLAG_Z], 2'b00, ~ci};
            end
            cpuaf_pkg::CMD_SCF:
            begin
                r = {8'h00, a};
                f = {item.flags_in[cpuaf_pkg::FLAG_Z], 2'b00, 1'b1};
            end
            cpuaf_pkg::CMD_ADD16:
            begin
                r = sum17[15:0];
                f = {item.flags_in[cpuaf_pkg::FLAG_Z], 1'b0, hsum13[12], sum17[16]};
            end
            cpuaf_pkg::CMD_ADD_SP:
            begin
                r = sp16;
                f = {2'b00, sph5[4], spc9[8]};
            end
            default:
            begin
                // Unassigned code: pass the item through unchanged.
                r = item.operand_a;
                f = item.flags_in;
            end
        endcase
    end

    assign res.result    = r;
    assign res.flags_out = f;

endmodule

// ===== hw/rtl/cpuaf_checker.sv =====
`timescale 1ns / 1ps

module cpuaf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [4:0]  cmd,
    input  logic [15:0] operand_a,
    input  logic        done,
    input  logic [15:0] result,
    input  logic [3:0]  flags_out
);

    // Every item taken gives exactly one result, marked by done once it has passed the input and result registers.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("item taken without a result two cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result strobe without an item");

    // Compare leaves the operand unchanged and always flags a subtraction.
    a_cp_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == cpuaf_pkg::CMD_CP)) |->
            ##2 (result == $past(operand_a, 2)) && flags_out[cpuaf_pkg::FLAG_N])
        else $error("compare changed the operand or missed N");

    a_logic_n_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((cmd == cpuaf_pkg::CMD_AND) || (cmd == cpuaf_pkg::CMD_XOR)
            || (cmd == cpuaf_pkg::CMD_OR))) |->
            ##2 (result[15:8] == 8'h00) && !flags_out[cpuaf_pkg::FLAG_N]
                && !flags_out[cpuaf_pkg::FLAG_C])
        else $error("logic operation set N or C or a high result byte");

endmodule

bind cpu_alu_with_flags_core cpuaf_checker u_cpuaf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .operand_a (operand_a),
    .done      (done),
    .result    (result),
    .flags_out (flags_out)
);
